### design/single_cycle_riscv_core_top_macros.svh
// Assertion macros shared by the checker files of the single-cycle core.
// No dependencies; include with the bare file name.
`ifndef SINGLE_CYCLE_RISCV_CORE_TOP_MACROS_SVH
`define SINGLE_CYCLE_RISCV_CORE_TOP_MACROS_SVH

// Clocked property, disabled while reset is low
`define SC_RV_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Implication that applies only while a condition holds
`define SC_RV_ASSERT_WHEN(name, clk, rstn, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

`endif

### design/sc_rv_pkg.sv
// Shared types and constants of the single-cycle RV32I subset core.
// No dependencies.
package sc_rv_pkg;

    // Major opcodes that the core executes
    localparam logic [6:0] OPC_R   = 7'd51;
    localparam logic [6:0] OPC_I   = 7'd19;
    localparam logic [6:0] OPC_LW  = 7'd3;
    localparam logic [6:0] OPC_SW  = 7'd35;
    localparam logic [6:0] OPC_BEQ = 7'd99;

    // funct codes that pick the ALU operation
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [6:0] F7_BASE = 7'd0;
    localparam logic [6:0] F7_SUB  = 7'd32;

    typedef enum logic [3:0] {
        ALU_AND = 4'b0000,
        ALU_OR  = 4'b0001,
        ALU_ADD = 4'b0010,
        ALU_SUB = 4'b0110
    } alu_op_t;

    // Execute-unit results for one instruction
    typedef struct packed {
        logic [31:0] next_pc;
        logic        rf_we;     // writes a register other than x0
        logic        is_load;
        logic        is_store;
        logic [4:0]  rd;
        logic [31:0] alu_val;   // register value for non-load writers
        logic [29:0] mem_idx;   // word index of the effective address
        logic [31:0] store_val;
    } ex_res_t;

endpackage

### design/sc_rv_exec.sv
// Decode, ALU, address and branch logic of the single-cycle core.
// Depends on sc_rv_pkg.
module sc_rv_exec (
    input  logic [31:0]        instr,
    input  logic [31:0]        rs1_val,
    input  logic [31:0]        rs2_val,
    input  logic [31:0]        pc,
    output sc_rv_pkg::ex_res_t res
);
    import sc_rv_pkg::*;

    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] alu_b;
    logic [31:0] addr;
    logic [31:0] alu_out;
    logic        is_r;
    logic        writes;
    alu_op_t     sel;

    assign op = instr[6:0];
    assign f3 = instr[14:12];
    assign f7 = instr[31:25];

    // Immediates
    assign imm_i = {{20{instr[31]}}, instr[31:20]};
    assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
    assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};

    assign is_r = (op == OPC_R);

    // ALU operation select; unknown funct falls back to AND
    always_comb
    begin
        case (f3)
            F3_ADD:
            begin
                if (!is_r || f7 == F7_BASE)
                    sel = ALU_ADD;
                else if (f7 == F7_SUB)
                    sel = ALU_SUB;
                else
                    sel = ALU_AND;
            end
            F3_OR:   sel = ALU_OR;
            default: sel = ALU_AND;
        endcase
    end

    assign alu_b = is_r ? rs2_val : imm_i;

    always_comb
    begin
        case (sel)
            ALU_OR:  alu_out = rs1_val | alu_b;
            ALU_ADD: alu_out = rs1_val + alu_b;
            ALU_SUB: alu_out = rs1_val - alu_b;
            default: alu_out = rs1_val & alu_b;
        endcase
    end

    // Effective byte address of loads and stores
    assign addr = rs1_val + ((op == OPC_SW) ? imm_s : imm_i);

    assign writes = (op == OPC_R) || (op == OPC_I) || (op == OPC_LW);

    always_comb
    begin
        res.rf_we     = writes && (instr[11:7] != 5'd0);
        res.is_load   = (op == OPC_LW);
        res.is_store  = (op == OPC_SW);
        res.rd        = instr[11:7];
        res.alu_val   = alu_out;
        res.mem_idx   = addr[31:2];
        res.store_val = rs2_val;
        // beq taken when operands match
        if (op == OPC_BEQ && rs1_val == rs2_val)
            res.next_pc = pc + imm_b;
        else
            res.next_pc = pc + 32'd4;
    end

endmodule

### design/single_cycle_riscv_core_top.sv
// Top level of the RV32I subset core: input stage, execute, result stage.
// Depends on sc_rv_pkg and sc_rv_exec.
//
//  channel | dir | beat contents
//  --------+-----+--------------------------------------------------------
//  s_*     | in  | one instruction word
//  m_*     | out | next pc, register write, memory write of that instruction
//
// One instruction per cycle sustained while m_tready stays high; an instruction beat
// passes the operand read stage, then execute into the result stage, before its result beat.
// The data memory read is registered, so load data is muxed out of the result
// stage and forwarded from there to the following instruction.
// After reset the data memory is cleared one word a cycle: s_tready stays low
// until the last word is cleared. A low m_tready holds the result; the input stage still
// takes a beat while it is empty.
module single_cycle_riscv_core_top #(
    parameter int MEM_WORDS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] instruction_word
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata    // next_address[31:0], reg_write_done[32],
                                    // reg_index[37:33], reg_value[69:38],
                                    // mem_write_done[70], mem_word_index[75:71],
                                    // mem_value[107:76], zero pad [111:108]
);
    import sc_rv_pkg::*;

    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(MEM_WORDS - 1);

    // Storage
    logic [31:0] rf_mem [32];
    logic [31:0] dmem [MEM_WORDS];
    logic [31:0] rf_valid_reg;

    // Architectural state
    logic [31:0] pc_reg;
    logic [31:0] llv_reg;

    // Clearing pass
    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;

    // Operand stage
    logic        s1_valid_reg;
    logic [31:0] s1_instr_reg;
    logic [31:0] s1_rf_a_reg, s1_rf_b_reg;
    logic        s1_rfv_a_reg, s1_rfv_b_reg;
    logic        s1_byp_a_reg, s1_byp_b_reg;
    logic [31:0] s1_bval_a_reg, s1_bval_b_reg;

    // Result stage
    logic        s2_valid_reg;
    logic [31:0] s2_next_pc_reg;
    logic        s2_wr_reg;
    logic [4:0]  s2_rd_reg;
    logic [31:0] s2_val_reg;
    logic        s2_is_load_reg;
    logic        s2_hit_reg;
    logic [31:0] s2_rdata_reg;
    logic        s2_mw_reg;
    logic [4:0]  s2_midx_reg;
    logic [31:0] s2_mval_reg;

    logic        accept, s1_adv, s2_leave;
    logic [4:0]  s_rs1, s_rs2, s1_rs1, s1_rs2;
    logic [31:0] op_a, op_b;
    logic [31:0] load_val, res_val;
    logic        mem_hit;
    ex_res_t     ex;

    // Handshake and stage advance
    assign s2_leave = s2_valid_reg && m_tready;
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || m_tready);
    assign s_tready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign accept   = s_tvalid && s_tready;

    assign s_rs1  = s_tdata[19:15];
    assign s_rs2  = s_tdata[24:20];
    assign s1_rs1 = s1_instr_reg[19:15];
    assign s1_rs2 = s1_instr_reg[24:20];

    // Value of the instruction in the result stage
    assign load_val = s2_hit_reg ? s2_rdata_reg : llv_reg;
    assign res_val  = s2_is_load_reg ? load_val : s2_val_reg;

    // Operands: result-stage forward, then capture bypass, then register file
    always_comb
    begin
        if (s2_valid_reg && s2_wr_reg && s2_rd_reg == s1_rs1)
            op_a = res_val;
        else if (s1_byp_a_reg)
            op_a = s1_bval_a_reg;
        else if (s1_rfv_a_reg)
            op_a = s1_rf_a_reg;
        else
            op_a = 32'd0;

        if (s2_valid_reg && s2_wr_reg && s2_rd_reg == s1_rs2)
            op_b = res_val;
        else if (s1_byp_b_reg)
            op_b = s1_bval_b_reg;
        else if (s1_rfv_b_reg)
            op_b = s1_rf_b_reg;
        else
            op_b = 32'd0;
    end

    sc_rv_exec u_exec (
        .instr   (s1_instr_reg),
        .rs1_val (op_a),
        .rs2_val (op_b),
        .pc      (pc_reg),
        .res     (ex)
    );

    assign mem_hit = ({2'b00, ex.mem_idx} < 32'(MEM_WORDS));

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            pc_reg       <= 32'd0;
            llv_reg      <= 32'd0;
            rf_valid_reg <= 32'd0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_IDX)
                    clearing_reg <= 1'b0;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
                pc_reg       <= ex.next_pc;
            end
            else if (s2_leave)
                s2_valid_reg <= 1'b0;
            // Retire: register write and last-load tracking
            if (s2_leave)
            begin
                if (s2_wr_reg)
                    rf_valid_reg[s2_rd_reg] <= 1'b1;
                if (s2_is_load_reg && s2_hit_reg)
                    llv_reg <= s2_rdata_reg;
            end
        end
    end

    // Register file: registered reads on accept, one write port on retire
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rf_a_reg <= rf_mem[s_rs1];
            s1_rf_b_reg <= rf_mem[s_rs2];
        end
        if (s2_leave && s2_wr_reg)
            rf_mem[s2_rd_reg] <= res_val;
    end

    // Operand stage payload and bypass of the retiring write
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_instr_reg  <= s_tdata;
            s1_rfv_a_reg  <= rf_valid_reg[s_rs1];
            s1_rfv_b_reg  <= rf_valid_reg[s_rs2];
            s1_byp_a_reg  <= s2_leave && s2_wr_reg && (s2_rd_reg == s_rs1);
            s1_byp_b_reg  <= s2_leave && s2_wr_reg && (s2_rd_reg == s_rs2);
            s1_bval_a_reg <= res_val;
            s1_bval_b_reg <= res_val;
        end
    end

    // Data memory: clearing pass, store on execute, registered load read
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            dmem[clr_cnt_reg] <= 32'd0;
        else if (s1_adv && ex.is_store && mem_hit)
            dmem[ex.mem_idx[AW-1:0]] <= ex.store_val;
        if (s1_adv && ex.is_load && mem_hit)
            s2_rdata_reg <= dmem[ex.mem_idx[AW-1:0]];
    end

    // Result stage payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_next_pc_reg <= ex.next_pc;
            s2_wr_reg      <= ex.rf_we;
            s2_rd_reg      <= ex.rf_we ? ex.rd : 5'd0;
            s2_val_reg     <= (ex.rf_we && !ex.is_load) ? ex.alu_val : 32'd0;
            s2_is_load_reg <= ex.is_load;
            s2_hit_reg     <= mem_hit;
            s2_mw_reg      <= ex.is_store && mem_hit;
            s2_midx_reg    <= (ex.is_store && mem_hit) ? ex.mem_idx[4:0] : 5'd0;
            s2_mval_reg    <= (ex.is_store && mem_hit) ? ex.store_val : 32'd0;
        end
    end

    // Result beat
    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = {4'd0, s2_mval_reg, s2_midx_reg, s2_mw_reg,
                       (s2_wr_reg ? res_val : 32'd0), s2_rd_reg, s2_wr_reg,
                       s2_next_pc_reg};

endmodule

### design/sc_rv_checker.sv
// Port-level checks of the single-cycle core, bound to the top level.
// Depends on single_cycle_riscv_core_top_macros.svh.
`include "single_cycle_riscv_core_top_macros.svh"

module sc_rv_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata
);

    // A held result beat keeps its contents
    `SC_RV_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // No register write: index and value read as zero
    `SC_RV_ASSERT_WHEN(a_reg_idle, clk, rst_n, m_tvalid && !m_tdata[32], m_tdata[37:33] == 5'd0 && m_tdata[69:38] == 32'd0, "idle register fields not zero")

    // A register write never targets x0
    `SC_RV_ASSERT_WHEN(a_reg_x0, clk, rst_n, m_tvalid && m_tdata[32], m_tdata[37:33] != 5'd0, "register write reported for x0")

    // A store never writes a register
    `SC_RV_ASSERT_WHEN(a_store_no_reg, clk, rst_n, m_tvalid && m_tdata[70], !m_tdata[32], "store also wrote a register")

    // Memory clearing blocks input right after reset
    `SC_RV_ASSERT_WHEN(a_clear_block, clk, rst_n, !$past(rst_n), !s_tready && !m_tvalid, "beat possible right after reset")

endmodule

bind single_cycle_riscv_core_top sc_rv_checker u_sc_rv_checker (.*);

### tb/sv/rv_retire_checker.sv
`timescale 1ns / 1ps
// Result checker for single_cycle_riscv_core_top. It predicts how each instruction
// beat retires and compares the prediction with the result beats field by field.
// Depends on sc_rv_pkg.
module rv_retire_checker #(
    parameter int MEM_WORDS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [31:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [111:0] m_tdata,
    output int unsigned  fail_count,
    output int unsigned  pending
);
    import sc_rv_pkg::*;

    // Result beat layout, highest field first so that it overlays m_tdata[107:0]
    typedef struct packed {
        logic [31:0] mem_value;
        logic [4:0]  mem_word_index;
        logic        mem_write_done;
        logic [31:0] reg_value;
        logic [4:0]  reg_index;
        logic        reg_write_done;
        logic [31:0] next_address;
    } retire_t;

    // Architectural state of the predicted core
    logic [31:0] pc_q;
    logic [31:0] regs_q [32];
    logic [31:0] dmem_q [MEM_WORDS];
    logic [31:0] last_load_q;

    retire_t     retire_q [$];
    int unsigned errors = 0;

    function automatic alu_op_t pick_alu(logic [2:0] f3, logic [6:0] f7, logic is_r);
        if (f3 == F3_ADD)
        begin
            // funct7 only matters for register-register forms
            if (!is_r || f7 == F7_BASE)
                return ALU_ADD;
            if (f7 == F7_SUB)
                return ALU_SUB;
            return ALU_AND;
        end
        if (f3 == F3_OR)
            return ALU_OR;
        return ALU_AND;
    endfunction

    function automatic logic [31:0] alu(logic [31:0] a, logic [31:0] b, alu_op_t op);
        case (op)
            ALU_OR:  return a | b;
            ALU_ADD: return a + b;
            ALU_SUB: return a - b;
            default: return a & b;
        endcase
    endfunction

    // Executes one instruction on the predicted state and returns its retirement
    function automatic retire_t execute_insn(logic [31:0] w);
        retire_t     r;
        logic [6:0]  opc;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        logic [31:0] imm_b;
        logic [31:0] addr;
        logic [31:0] nxt;
        logic [31:0] val;
        logic        rf_we;
        opc   = w[6:0];
        rd    = w[11:7];
        f3    = w[14:12];
        rs1   = w[19:15];
        rs2   = w[24:20];
        f7    = w[31:25];
        a     = regs_q[rs1];
        b     = regs_q[rs2];
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        nxt   = pc_q + 32'd4;
        val   = '0;
        rf_we = 1'b0;
        r     = '0;
        case (opc)
            OPC_R:
            begin
                val   = alu(a, b, pick_alu(f3, f7, 1'b1));
                rf_we = 1'b1;
            end
            OPC_I:
            begin
                val   = alu(a, imm_i, pick_alu(f3, f7, 1'b0));
                rf_we = 1'b1;
            end
            OPC_LW:
            begin
                // a miss keeps handing out the last word loaded
                addr = a + imm_i;
                if (addr[31:2] < MEM_WORDS)
                    last_load_q = dmem_q[addr[31:2]];
                val   = last_load_q;
                rf_we = 1'b1;
            end
            OPC_SW:
            begin
                addr = a + imm_s;
                if (addr[31:2] < MEM_WORDS)
                begin
                    dmem_q[addr[31:2]] = b;
                    r.mem_write_done   = 1'b1;
                    r.mem_word_index   = addr[6:2];
                    r.mem_value        = b;
                end
            end
            OPC_BEQ:
            begin
                if (alu(a, b, ALU_SUB) == '0)
                    nxt = pc_q + imm_b;
            end
            default:
            begin
            end
        endcase
        // x0 is never written and reports no write
        if (rf_we && rd != 5'd0)
        begin
            regs_q[rd]       = val;
            r.reg_write_done = 1'b1;
            r.reg_index      = rd;
            r.reg_value      = val;
        end
        pc_q           = nxt;
        r.next_address = nxt;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            errors++;
            $display("%0t ns: %s expected %h, actual %h", $time, name, want_v, got_v);
        end
    endtask

    // Predict on every instruction beat, compare on every result beat
    always @(posedge clk or negedge rst_n)
    begin : watch
        retire_t got;
        retire_t want;
        if (!rst_n)
        begin
            pc_q        = '0;
            last_load_q = '0;
            foreach (regs_q[i])
                regs_q[i] = '0;
            foreach (dmem_q[i])
                dmem_q[i] = '0;
            retire_q.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                retire_q.push_back(execute_insn(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = retire_t'(m_tdata[107:0]);
                if (retire_q.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result beat expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = retire_q.pop_front();
                    check_field("next_address", want.next_address, got.next_address);
                    check_field("reg_write_done", 32'(want.reg_write_done),
                                32'(got.reg_write_done));
                    check_field("reg_index", 32'(want.reg_index), 32'(got.reg_index));
                    check_field("reg_value", want.reg_value, got.reg_value);
                    check_field("mem_write_done", 32'(want.mem_write_done),
                                32'(got.mem_write_done));
                    check_field("mem_word_index", 32'(want.mem_word_index),
                                32'(got.mem_word_index));
                    check_field("mem_value", want.mem_value, got.mem_value);
                end
            end
        end
        pending    <= retire_q.size();
        fail_count <= errors;
    end

endmodule

### tb/sv/tb_single_cycle_riscv_core_top.sv
`timescale 1ns / 1ps
// Testbench top for single_cycle_riscv_core_top: clock, reset, instruction beats
// in bursts, result-side stalls, watchdog and verdict.
// Depends on sc_rv_pkg, the core RTL and rv_retire_checker.
module tb_single_cycle_riscv_core_top;
    import sc_rv_pkg::*;

    localparam int MEM_WORDS    = 32;
    localparam int RANDOM_INSNS = 1925;
    localparam int DRAIN_AT     = 900;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 500;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 16;

    // Encodings the core does not execute, plus funct3 values used by the stimulus
    localparam logic [6:0] OPC_LUI = 7'd55;
    localparam logic [6:0] OPC_JAL = 7'd111;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;

    int unsigned  fail_count;
    int unsigned  pending;
    int unsigned  idle_cycles  = 0;
    int unsigned  results_seen = 0;
    int unsigned  burst_left   = 0;

    always #4 clk = ~clk;

    single_cycle_riscv_core_top #(
        .MEM_WORDS(MEM_WORDS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rv_retire_checker #(
        .MEM_WORDS(MEM_WORDS)
    ) retire_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Instruction encoders
    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OPC_R};
    endfunction

    function automatic logic [31:0] enc_i(logic [6:0] opc, logic [11:0] imm, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1);
        return {imm[11:5], rs2, rs1, F3_WORD, imm[4:0], OPC_SW};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] off, logic [4:0] rs2, logic [4:0] rs1);
        return {off[12], off[10:5], rs2, rs1, F3_BEQ, off[4:1], off[11], OPC_BEQ};
    endfunction

    // Random instruction mix; memory offsets mostly land near word 0 so loads hit
    function automatic logic [31:0] random_insn();
        int unsigned pick;
        logic [6:0]  f7;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [4:0]  mbase;
        logic [11:0] imm;
        logic [11:0] moff;
        pick = $urandom_range(0, 99);
        rd   = 5'($urandom);
        rs1  = 5'($urandom);
        rs2  = 5'($urandom);
        imm  = 12'($urandom);
        case ($urandom_range(0, 3))
            0:       f3 = F3_ADD;
            1:       f3 = F3_OR;
            2:       f3 = F3_AND;
            default: f3 = 3'($urandom);
        endcase
        if ($urandom_range(0, 9) < 6)
            f7 = F7_BASE;
        else if ($urandom_range(0, 2) != 0)
            f7 = F7_SUB;
        else
            f7 = 7'($urandom);
        mbase = ($urandom_range(0, 9) < 6) ? 5'd0 : rs1;
        case ($urandom_range(0, 5))
            0:       moff = 12'($urandom);
            1:       moff = 12'(-$urandom_range(1, 16));
            default: moff = 12'($urandom_range(0, 4 * MEM_WORDS + 7));
        endcase
        if (pick < 20)
            return enc_r(f7, rs2, rs1, f3, rd);
        if (pick < 40)
        begin
            // small constants in registers give useful load and store bases
            if ($urandom_range(0, 2) == 0)
            begin
                rs1 = 5'd0;
                imm = 12'($urandom_range(0, 4 * MEM_WORDS));
                f3  = F3_ADD;
            end
            return enc_i(OPC_I, imm, rs1, f3, rd);
        end
        if (pick < 55)
            return enc_i(OPC_LW, moff, mbase,
                         ($urandom_range(0, 9) == 0) ? 3'($urandom) : F3_WORD, rd);
        if (pick < 70)
            return enc_s(moff, rs2, mbase);
        if (pick < 85)
        begin
            if ($urandom_range(0, 1) == 1)
                rs2 = rs1;
            return enc_b(13'($urandom), rs2, rs1);
        end
        if (pick < 93)
        begin
            case ($urandom_range(0, 3))
                0: opc = OPC_LUI;
                1: opc = OPC_JAL;
                default:
                begin
                    do
                        opc = 7'($urandom);
                    while (opc == OPC_R || opc == OPC_I || opc == OPC_LW ||
                           opc == OPC_SW || opc == OPC_BEQ);
                end
            endcase
            return {25'($urandom), opc};
        end
        return $urandom;
    endfunction

    // One instruction beat; bursts of random length separated by random gaps
    task automatic send_insn(logic [31:0] w);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 60);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
    endtask

    // Watchdog on beats of either side, plus a count of result beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                results_seen <= results_seen + 1;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: stall patterns in phases, and one long hold-off
    initial
    begin : result_side
        int unsigned mode;
        int unsigned span;
        bit          held;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 80);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                @(posedge clk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        logic [31:0] directed [$];
        directed = '{
            enc_i(OPC_I, 12'd5, 5'd0, F3_ADD, 5'd1),        // small positive
            enc_i(OPC_I, 12'hFFF, 5'd0, F3_ADD, 5'd2),      // all ones
            enc_i(OPC_I, 12'h7FF, 5'd0, F3_ADD, 5'd3),      // largest immediate
            enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd4),
            enc_r(F7_SUB, 5'd3, 5'd1, F3_ADD, 5'd5),
            enc_r(F7_BASE, 5'd3, 5'd2, F3_AND, 5'd6),
            enc_r(F7_BASE, 5'd3, 5'd1, F3_OR, 5'd7),
            enc_r(7'd1, 5'd2, 5'd3, F3_ADD, 5'd8),          // odd funct7 falls back to and
            enc_r(7'h7F, 5'd2, 5'd1, F3_OR, 5'd9),
            enc_r(F7_BASE, 5'd2, 5'd5, F3_XOR, 5'd10),      // unsupported funct3
            enc_i(OPC_I, 12'h0F0, 5'd2, F3_AND, 5'd11),
            enc_i(OPC_I, 12'h800, 5'd1, F3_OR, 5'd12),      // most negative immediate
            enc_i(OPC_I, 12'hFFF, 5'd2, F3_SLL, 5'd13),
            enc_s(12'd124, 5'd7, 5'd0),                     // top word of the store
            enc_s(12'd0, 5'd2, 5'd1),
            enc_s(12'd128, 5'd1, 5'd0),                     // just past the store
            enc_s(12'hFFC, 5'd3, 5'd0),                     // negative address
            enc_i(OPC_LW, 12'd124, 5'd0, F3_WORD, 5'd14),
            enc_i(OPC_LW, 12'd128, 5'd0, F3_WORD, 5'd15),   // miss repeats last load
            enc_i(OPC_LW, 12'hFFF, 5'd1, F3_WORD, 5'd16),   // negative offset, unaligned
            enc_r(F7_BASE, 5'd1, 5'd1, F3_ADD, 5'd0),       // write to x0
            enc_i(OPC_LW, 12'd4, 5'd0, F3_WORD, 5'd0),
            enc_b(13'h1000, 5'd1, 5'd1),                    // taken, farthest back
            enc_b(13'h0FFE, 5'd2, 5'd1),                    // not taken
            enc_b(13'd8, 5'd0, 5'd0),
            {20'hFFFFF, 5'd18, OPC_LUI},
            {20'h12345, 5'd1, OPC_JAL},
            32'hFFFF_FFFF,
            32'h0000_0000
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed[i])
            send_insn(directed[i]);
        for (int n = 0; n < RANDOM_INSNS; n++)
        begin
            // once mid-run, let the core drain completely
            if (n == DRAIN_AT)
            begin
                s_tvalid <= 1'b0;
                burst_left = 0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            send_insn(random_insn());
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/sc_rv_pkg.sv
design/sc_rv_exec.sv
design/single_cycle_riscv_core_top.sv
design/sc_rv_checker.sv
tb/sv/rv_retire_checker.sv
tb/sv/tb_single_cycle_riscv_core_top.sv
